FILE: src/sdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg
// shared constants and controller/datapath interface types of the
// sequence duplicate filter
// ----------------------------------------------------------------------------
package sdf_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 8192;
	localparam logic [15:0] FILL_VALUE      = 16'hAAAA;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd180;

	// apb register map: one register per 4 bytes, word index in paddr[2]
	localparam int unsigned ADDR_W          = 3;
	localparam logic        REG_TIMEOUT     = 1'b0;

	// controller to datapath
	typedef struct packed {
		logic accept;    // capture input word, start slot and timeout math
		logic slot_ld;   // register the reduced table index
		logic sweep_wr;  // write fill value at sweep counter
		logic rd_en;     // read table entry at slot
		logic commit;    // write back, update time, load result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic timeout_hit; // elapsed time exceeded the timeout
		logic sweep_last;  // sweep counter at last entry
	} sts_t;

endpackage

FILE: src/sequence_duplicate_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_duplicate_filter
// drops packets whose sequence number was already seen since the last timeout
// ----------------------------------------------------------------------------
// usage
//   input word: sequence_number and now_seconds, taken when in_valid is high
//   and in_stall is low. output word: is_repeat and table_was_cleared, taken
//   when out_valid is high and out_stall is low. one output word per input.
//   timeout_seconds sits at apb byte address 0, writable and readable.
// sequence
//   after accept the controller steps through SLOT, SWEEP, READ and DONE;
//   no new word is taken until DONE hands the result off. the path is index
//   reduction (multiply by reciprocal, then back-multiply and correct), one
//   registered read of the single table memory, then compare and write back.
//   SWEEP runs only past the timeout and writes the fill value, one entry a cycle.
// reset
//   after arst_n releases, a fill pass writes 0xAAAA to every entry while
//   in_stall stays high. apb writes are taken meanwhile.
// stalls
//   a new word is accepted while a result waits in the output register; a
//   second result waits in the datapath until the output register frees.
// ----------------------------------------------------------------------------
module sequence_duplicate_filter #(
	parameter int unsigned TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,

	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [15:0]               sequence_number,
	input  logic [31:0]               now_seconds,

	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      is_repeat,
	output logic                      table_was_cleared,

	// apb configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [sdf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	sdf_pkg::cmd_t cmd;
	sdf_pkg::sts_t sts;

	logic [15:0] timeout_q;
	logic        cfg_wr;
	logic        sel_timeout;

	// register word index is paddr[2]; byte offsets within a word are ignored
	assign sel_timeout = (paddr[2] == sdf_pkg::REG_TIMEOUT);
	assign pready      = 1'b1;
	assign cfg_wr      = psel & penable & pwrite & pready;
	assign prdata      = sel_timeout ? {16'd0, timeout_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= sdf_pkg::TIMEOUT_RESET;
		end else if (cfg_wr && sel_timeout) begin
			timeout_q <= pwdata[15:0];
		end
	end

	// sequencer: fill sweeps, lookup steps, output handoff
	sdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// table memory, index math, timeout compare and result word
	sdf_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.sequence_number   (sequence_number),
		.now_seconds       (now_seconds),
		.timeout_seconds   (timeout_q),
		.is_repeat         (is_repeat),
		.table_was_cleared (table_was_cleared)
	);

endmodule

FILE: src/sdf_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_dpath
// table memory, index reduction, timeout compare, sweep counter and result
// registers
// ----------------------------------------------------------------------------
module sdf_dpath #(
	parameter int unsigned TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sdf_pkg::cmd_t cmd,
	output sdf_pkg::sts_t sts,
	input  logic [15:0]   sequence_number,
	input  logic [31:0]   now_seconds,
	input  logic [15:0]   timeout_seconds,
	output logic          is_repeat,
	output logic          table_was_cleared
);

	localparam int unsigned AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / TABLE_DEPTH);
	localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST  = AW'(TABLE_DEPTH - 1);

	logic [15:0]   mem [TABLE_DEPTH];

	logic [15:0]   seq_q;
	logic [31:0]   now_q;
	logic [15:0]   quot_s1;
	logic          hit_q;
	logic [AW-1:0] slot_q;
	logic [15:0]   rdata_q;
	logic [31:0]   last_q;
	logic [AW-1:0] cnt_q;
	logic          rep_q;
	logic          clr_q;

	logic [48:0]   recip_prod;
	logic [31:0]   elapsed;
	logic [32:0]   back_prod;
	logic [16:0]   rem_raw;
	logic [16:0]   rem_fix;
	logic          mismatch;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;

	// quotient estimate, off by at most one below the true value
	assign recip_prod = {33'd0, sequence_number} * {16'd0, RECIP};
	assign elapsed    = now_seconds - last_q;

	assign back_prod  = {17'd0, quot_s1} * {16'd0, DEPTH17};
	assign rem_raw    = {1'b0, seq_q} - back_prod[16:0];
	assign rem_fix    = (rem_raw >= DEPTH17) ? (rem_raw - DEPTH17) : rem_raw;

	assign mismatch   = (rdata_q != seq_q);

	assign mem_we     = cmd.sweep_wr | (cmd.commit & mismatch);
	assign mem_waddr  = cmd.sweep_wr ? cnt_q : slot_q;
	assign mem_wdata  = cmd.sweep_wr ? sdf_pkg::FILL_VALUE : seq_q;

	assign sts.timeout_hit = hit_q;
	assign sts.sweep_last  = (cnt_q == LAST);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			seq_q   <= sequence_number;
			now_q   <= now_seconds;
			quot_s1 <= recip_prod[47:32];
			hit_q   <= (elapsed > {16'd0, timeout_seconds});
		end
		if (cmd.slot_ld) begin
			slot_q <= rem_fix[AW-1:0];
		end
		if (cmd.commit) begin
			rep_q <= ~mismatch;
			clr_q <= hit_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.commit && (mismatch || hit_q)) begin
				last_q <= now_q;
			end
			if (cmd.sweep_wr) begin
				cnt_q <= sts.sweep_last ? '0 : cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	assign is_repeat         = rep_q;
	assign table_was_cleared = clr_q;

endmodule

FILE: src/sdf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_ctrl
// sequencer for fill sweeps, lookup and result handoff
// ----------------------------------------------------------------------------
module sdf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output sdf_pkg::cmd_t cmd,
	input  sdf_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SLOT,
		ST_SWEEP,
		ST_READ,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = ~out_valid_q | ~out_stall;

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == ST_IDLE) & in_valid;
		cmd.slot_ld  = (state_q == ST_SLOT);
		cmd.sweep_wr = (state_q == ST_INIT) | (state_q == ST_SWEEP);
		cmd.rd_en    = (state_q == ST_READ);
		cmd.commit   = (state_q == ST_DONE) & out_free;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (sts.sweep_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SLOT;
				end
				ST_SLOT: begin
					state_q <= sts.timeout_hit ? ST_SWEEP : ST_READ;
				end
				ST_SWEEP: begin
					if (sts.sweep_last) state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

endmodule
